// ----- sv/qsort3_pkg.sv -----
// ============================================================================
// qsort3_pkg: shared types and constants for the three-way quicksort engine
// Request structs for both channels, the sequencer state type and defaults.
// ============================================================================
package qsort3_pkg;

    // Default configuration handed to the top level parameters.
    localparam int MAX_ITEMS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed width of the value fields on both channels.
    localparam int FIELD_BITS = 32;

    // One input request: an element and the end-of-set mark.
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] value;
        logic                         last;
    } t_in_req;

    // One output request: a sorted element with its run flags.
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] sorted_value;
        logic                         last_out;
        logic                         overflow;
    } t_out_req;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_START,
        ST_POP,
        ST_POP_WAIT,
        ST_PIV_RD,
        ST_PIV_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_PUSH_A,
        ST_PUSH_B,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } t_qs_state;

endpackage

// ----- sv/three_way_quicksort_engine.sv -----
// ============================================================================
// three_way_quicksort_engine: sorting engine with three-way partitioning
// Collects a set of signed values, sorts it in place with an iterative
// quicksort driven by a range stack, and streams the sorted set out.
// ============================================================================
// Usage:
// The input channel (i_in_valid / o_in_ready / i_in_req) takes one value per
// cycle while the engine is loading. A request with last set closes the set;
// o_in_ready then stays low until every sorted value has been delivered.
// The output channel (o_out_valid / i_out_ready / o_out_req) gives one value
// per request in ascending order; last_out marks the final one and overflow
// is set on all of them if requests were dropped because the store was full.
// Sorting runs on the element store's single read and write ports under a
// small sequencer: each scanned element is read and compared with the pivot,
// and written to its new place in the swap states when it is moved; each
// popped range reads the stack, reads its pivot and pushes its subranges, and
// the sort also passes a start state and a final pop. Less and greater elements
// are always swapped, so n distinct random values take about 2 * n * ln(n)
// scans. Each output value is read, registered and then held until the receiver
// takes it, so the next value is not fetched before the current one is accepted;
// a stalled receiver simply holds the engine in place with the current value
// registered. Reset empties the store, the range stack and the overflow flag and returns the engine to loading.
// ============================================================================
module three_way_quicksort_engine #(
    parameter int MAX_ITEMS  = qsort3_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = qsort3_pkg::VALUE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  qsort3_pkg::t_in_req  i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output qsort3_pkg::t_out_req o_out_req
);

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int EW  = CW + 1;
    localparam int SD  = MAX_ITEMS + 2;
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int FB  = qsort3_pkg::FIELD_BITS;
    localparam logic [VALUE_BITS-1:0] KEY_SIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Control state.
    qsort3_pkg::t_qs_state r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_ovf, n_ovf;
    logic [SPW-1:0] r_sp, n_sp;

    // Datapath registers.
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_lt, n_lt;
    logic [CW-1:0]         r_gtp1, n_gtp1;
    logic [VALUE_BITS-1:0] r_pivot, n_pivot;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [AW-1:0]         r_swap_addr, n_swap_addr;
    logic                  r_less, n_less;
    logic [AW-1:0]         r_k, n_k;
    qsort3_pkg::t_out_req  r_out, n_out;

    // Memories and their ports.
    logic [VALUE_BITS-1:0] r_elem_mem [MAX_ITEMS];
    logic [VALUE_BITS-1:0] r_rd;
    logic                  el_we;
    logic [AW-1:0]         el_wa;
    logic [AW-1:0]         el_ra;
    logic [VALUE_BITS-1:0] el_wd;

    logic [2*AW-1:0] r_stk_mem [SD];
    logic [2*AW-1:0] r_stk_rd;
    logic            stk_we;
    logic [SAW-1:0]  stk_wa;
    logic [SAW-1:0]  stk_ra;
    logic [2*AW-1:0] stk_wd;

    // Helper signals.
    logic                  in_acc;
    logic                  out_acc;
    logic [VALUE_BITS-1:0] w_in_key;
    logic [VALUE_BITS-1:0] w_rd_raw;
    logic [FB-1:0]         w_rd_field;
    logic                  w_less;
    logic                  w_greater;
    logic                  w_scan_more;
    logic                  w_left_ok;
    logic                  w_right_ok;
    logic                  w_left_big;
    logic                  w_push_left;
    logic                  w_push_en;
    logic                  w_stk_room;
    logic [AW-1:0]         w_gt_addr;
    logic [AW-1:0]         w_piv_addr;
    logic                  w_out_last;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Input value to sort key: keep the low VALUE_BITS (zero-extended when wider), flip the sign bit.
    if (VALUE_BITS <= FB) begin : g_in_narrow
        assign w_in_key = i_in_req.value[VALUE_BITS-1:0] ^ KEY_SIGN;
    end else begin : g_in_wide
        assign w_in_key = {{(VALUE_BITS-FB){1'b0}}, i_in_req.value} ^ KEY_SIGN;
    end

    // Stored key back to the output field width.
    assign w_rd_raw = r_rd ^ KEY_SIGN;
    if (VALUE_BITS >= FB) begin : g_out_wide
        assign w_rd_field = w_rd_raw[FB-1:0];
    end else begin : g_out_narrow
        assign w_rd_field = {{(FB-VALUE_BITS){1'b0}}, w_rd_raw};
    end

    // Partition compare and range bookkeeping.
    assign w_less      = r_rd < r_pivot;
    assign w_greater   = r_rd > r_pivot;
    assign w_scan_more = r_idx < r_gtp1;
    assign w_gt_addr   = AW'(r_gtp1 - CW'(1));
    assign w_piv_addr  = r_lo + ((r_hi - r_lo) >> 1);
    assign w_left_ok   = EW'(r_lt) > (EW'(r_lo) + EW'(1));
    assign w_right_ok  = EW'(r_gtp1) < EW'(r_hi);
    assign w_left_big  = (EW'(r_lt) + EW'(r_gtp1)) > (EW'(r_lo) + EW'(r_hi) + EW'(1));
    assign w_stk_room  = r_sp < SPW'(SD);
    assign w_push_left = (r_state == qsort3_pkg::ST_PUSH_A) ? w_left_big : !w_left_big;
    assign w_push_en   = ((r_state == qsort3_pkg::ST_PUSH_A) ||
                          (r_state == qsort3_pkg::ST_PUSH_B)) &&
                         (w_push_left ? w_left_ok : w_right_ok) && w_stk_room;
    assign w_out_last  = (CW'(r_k) + CW'(1)) == r_count;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qsort3_pkg::ST_LOAD: begin
                if (in_acc && i_in_req.last) begin
                    n_state = qsort3_pkg::ST_SORT_START;
                end
            end
            qsort3_pkg::ST_SORT_START: n_state = qsort3_pkg::ST_POP;
            qsort3_pkg::ST_POP: begin
                if (r_sp == '0) begin
                    n_state = qsort3_pkg::ST_OUT_RD;
                end else begin
                    n_state = qsort3_pkg::ST_POP_WAIT;
                end
            end
            qsort3_pkg::ST_POP_WAIT:  n_state = qsort3_pkg::ST_PIV_RD;
            qsort3_pkg::ST_PIV_RD:    n_state = qsort3_pkg::ST_PIV_WAIT;
            qsort3_pkg::ST_PIV_WAIT:  n_state = qsort3_pkg::ST_SCAN_RD;
            qsort3_pkg::ST_SCAN_RD: begin
                if (w_scan_more) begin
                    n_state = qsort3_pkg::ST_SCAN_CMP;
                end else begin
                    n_state = qsort3_pkg::ST_PUSH_A;
                end
            end
            qsort3_pkg::ST_SCAN_CMP: begin
                if (w_less || w_greater) begin
                    n_state = qsort3_pkg::ST_SWAP_A;
                end else begin
                    n_state = qsort3_pkg::ST_SCAN_RD;
                end
            end
            qsort3_pkg::ST_SWAP_A:   n_state = qsort3_pkg::ST_SWAP_B;
            qsort3_pkg::ST_SWAP_B:   n_state = qsort3_pkg::ST_SCAN_RD;
            qsort3_pkg::ST_PUSH_A:   n_state = qsort3_pkg::ST_PUSH_B;
            qsort3_pkg::ST_PUSH_B:   n_state = qsort3_pkg::ST_POP;
            qsort3_pkg::ST_OUT_RD:   n_state = qsort3_pkg::ST_OUT_WAIT;
            qsort3_pkg::ST_OUT_WAIT: n_state = qsort3_pkg::ST_OUT_HOLD;
            qsort3_pkg::ST_OUT_HOLD: begin
                if (out_acc) begin
                    if (r_out.last_out) begin
                        n_state = qsort3_pkg::ST_LOAD;
                    end else begin
                        n_state = qsort3_pkg::ST_OUT_RD;
                    end
                end
            end
            default: n_state = qsort3_pkg::ST_LOAD;
        endcase
    end

    // Handshakes and memory port control.
    always_comb begin
        o_in_ready  = (r_state == qsort3_pkg::ST_LOAD);
        o_out_valid = (r_state == qsort3_pkg::ST_OUT_HOLD);
        el_we  = 1'b0;
        el_wa  = r_idx[AW-1:0];
        el_wd  = r_rd;
        el_ra  = r_idx[AW-1:0];
        stk_we = 1'b0;
        stk_wa = r_sp[SAW-1:0];
        stk_wd = w_push_left ? {r_lo, AW'(r_lt - CW'(1))} : {r_gtp1[AW-1:0], r_hi};
        stk_ra = SAW'(r_sp - SPW'(1));
        unique case (r_state)
            qsort3_pkg::ST_LOAD: begin
                el_we = in_acc && (r_count < CW'(MAX_ITEMS));
                el_wa = r_count[AW-1:0];
                el_wd = w_in_key;
            end
            qsort3_pkg::ST_SORT_START: begin
                stk_we = r_count > CW'(1);
                stk_wa = '0;
                stk_wd = {{AW{1'b0}}, AW'(r_count - CW'(1))};
            end
            qsort3_pkg::ST_PIV_RD: el_ra = w_piv_addr;
            qsort3_pkg::ST_SCAN_CMP: begin
                el_ra = w_less ? r_lt[AW-1:0] : w_gt_addr;
            end
            qsort3_pkg::ST_SWAP_A: el_we = 1'b1;
            qsort3_pkg::ST_SWAP_B: begin
                el_we = 1'b1;
                el_wa = r_swap_addr;
                el_wd = r_val;
            end
            qsort3_pkg::ST_PUSH_A, qsort3_pkg::ST_PUSH_B: stk_we = w_push_en;
            qsort3_pkg::ST_OUT_RD: el_ra = r_k;
            default: ;
        endcase
    end

    // Next values of the counters and datapath registers.
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_sp        = r_sp;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_lt        = r_lt;
        n_gtp1      = r_gtp1;
        n_pivot     = r_pivot;
        n_val       = r_val;
        n_swap_addr = r_swap_addr;
        n_less      = r_less;
        n_k         = r_k;
        n_out       = r_out;
        case (r_state)
            qsort3_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            qsort3_pkg::ST_SORT_START: begin
                n_sp = (r_count > CW'(1)) ? SPW'(1) : '0;
            end
            qsort3_pkg::ST_POP: begin
                n_k = '0;
                if (r_sp != '0) begin
                    n_sp = r_sp - SPW'(1);
                end
            end
            qsort3_pkg::ST_POP_WAIT: begin
                n_lo = r_stk_rd[2*AW-1:AW];
                n_hi = r_stk_rd[AW-1:0];
            end
            qsort3_pkg::ST_PIV_RD: begin
                n_idx  = CW'(r_lo);
                n_lt   = CW'(r_lo);
                n_gtp1 = CW'(r_hi) + CW'(1);
            end
            qsort3_pkg::ST_PIV_WAIT: n_pivot = r_rd;
            qsort3_pkg::ST_SCAN_CMP: begin
                n_val       = r_rd;
                n_less      = w_less;
                n_swap_addr = w_less ? r_lt[AW-1:0] : w_gt_addr;
                if (!w_less && !w_greater) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            qsort3_pkg::ST_SWAP_B: begin
                if (r_less) begin
                    n_lt  = r_lt + CW'(1);
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_gtp1 = r_gtp1 - CW'(1);
                end
            end
            qsort3_pkg::ST_PUSH_A, qsort3_pkg::ST_PUSH_B: begin
                if (w_push_en) begin
                    n_sp = r_sp + SPW'(1);
                end
            end
            qsort3_pkg::ST_OUT_WAIT: begin
                n_out.sorted_value = w_rd_field;
                n_out.last_out     = w_out_last;
                n_out.overflow     = r_ovf;
            end
            qsort3_pkg::ST_OUT_HOLD: begin
                if (out_acc) begin
                    if (r_out.last_out) begin
                        n_count = '0;
                        n_sp    = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qsort3_pkg::ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_sp    <= n_sp;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_idx       <= n_idx;
        r_lt        <= n_lt;
        r_gtp1      <= n_gtp1;
        r_pivot     <= n_pivot;
        r_val       <= n_val;
        r_swap_addr <= n_swap_addr;
        r_less      <= n_less;
        r_k         <= n_k;
        r_out       <= n_out;
    end

    // Element store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (el_we) begin
            r_elem_mem[el_wa] <= el_wd;
        end
        r_rd <= r_elem_mem[el_ra];
    end

    // Range stack: packed (low, high) pairs, registered read.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_rd <= r_stk_mem[stk_ra];
    end

    assign o_out_req = r_out;

    // The engine never loads and delivers at the same time.
    a_channels_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result is offered");

    // The store count never passes its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("item count above capacity");

    // During a partition pass the less-than boundary trails the scan index.
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qsort3_pkg::ST_SCAN_RD || r_state == qsort3_pkg::ST_SCAN_CMP)
        |-> (r_lt <= r_idx && r_idx <= r_gtp1))
        else $error("partition indexes out of order");

    // Delivering the final result reopens the input channel.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_req.last_out) |=> (o_in_ready && r_count == '0))
        else $error("engine did not return to loading after the run");

endmodule
